// File: rtl/bps_pkg.sv
// Shared types, character constants and byte classification for the pre-token splitter.
package bps_pkg;

  typedef enum logic [2:0] {
    CLS_IDLE    = 3'd0,
    CLS_NLRUN   = 3'd1,
    CLS_SPACE1  = 3'd2,
    CLS_LETTER  = 3'd3,
    CLS_PUNCT   = 3'd4,
    CLS_PUNCTNL = 3'd5,
    CLS_WSRUN   = 3'd6,
    CLS_APOS    = 3'd7
  } cls_t;

  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_HIGH   = 8'h80;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_M      = 8'h6D;
  localparam logic [7:0] CH_D      = 8'h64;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  // One released byte.
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       last;
  } ent_t;

  // Splitter state carried between bytes.
  typedef struct packed {
    cls_t       cls;
    logic [7:0] la0;
    logic [7:0] la1;
    logic [1:0] cnt;
  } st_t;

  // Outcome of one byte against an open run (no apostrophe lookahead pending).
  typedef struct packed {
    logic emit;
    logic start;
    cls_t cls;
    logic hold;
  } take_t;

  function automatic logic byte_alpha(input logic [7:0] b);
    return (b >= CH_LC_A && b <= CH_LC_Z) || (b >= CH_UC_A && b <= CH_UC_Z) || (b >= CH_HIGH);
  endfunction

  function automatic logic byte_num(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic logic byte_eol(input logic [7:0] b);
    return b == CH_LF || b == CH_CR;
  endfunction

  function automatic logic byte_ws(input logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic byte_punct(input logic [7:0] b);
    return !byte_ws(b) && !byte_alpha(b) && !byte_num(b);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= CH_UC_A && b <= CH_UC_Z) ? (b | CASE_BIT) : b;
  endfunction

  // Extend the open run with b, open a new pre-token at b, or hold b if it is an apostrophe at a boundary.
  function automatic take_t take_plain(input cls_t cls, input logic [7:0] b);
    take_t t;
    logic  ext;
    t     = '{emit: 1'b0, start: 1'b0, cls: cls, hold: 1'b0};
    ext   = 1'b0;
    case (cls)
      CLS_NLRUN: begin
        ext = byte_ws(b);
      end
      CLS_SPACE1: begin
        if (byte_alpha(b)) begin
          ext   = 1'b1;
          t.cls = CLS_LETTER;
        end else if (byte_punct(b)) begin
          ext   = 1'b1;
          t.cls = CLS_PUNCT;
        end
      end
      CLS_LETTER: begin
        ext = byte_alpha(b);
      end
      CLS_PUNCT: begin
        if (byte_punct(b)) begin
          ext = 1'b1;
        end else if (byte_eol(b)) begin
          ext   = 1'b1;
          t.cls = CLS_PUNCTNL;
        end
      end
      CLS_PUNCTNL: begin
        ext = byte_eol(b);
      end
      CLS_WSRUN: begin
        ext = byte_ws(b) && !byte_eol(b);
      end
      default: begin
        ext = 1'b0;
      end
    endcase
    if (ext) begin
      t.emit = 1'b1;
    end else if (b == CH_APOS) begin
      t.hold = 1'b1;
      t.cls  = CLS_APOS;
    end else begin
      t.emit  = 1'b1;
      t.start = 1'b1;
      if (byte_eol(b))         t.cls = CLS_NLRUN;
      else if (b == CH_SPACE)  t.cls = CLS_SPACE1;
      else if (byte_alpha(b))  t.cls = CLS_LETTER;
      else if (byte_num(b))    t.cls = CLS_IDLE;
      else if (byte_ws(b))     t.cls = CLS_WSRUN;
      else                     t.cls = CLS_PUNCT;
    end
    return t;
  endfunction

endpackage

// File: rtl/bpe_pretoken_splitter_top.sv
// Top level of the streaming pre-token splitter.
//
// Input channel in_*: one text byte per transfer, in_tdata = data_byte,
// in_tlast = end_of_text (final byte of the text).
// Output channel out_*: bytes in original order, one per transfer,
// out_tdata = out_byte, out_tuser = token_start, out_tlast = text_last.
// An input byte is first captured in an input register; when the result
// queue can take it, the split logic runs on it and loads 0 to 3 released
// bytes into the queue, which registers them; out_tvalid rises once the
// queue holds a byte.
// Throughput is one byte per cycle while the receiver accepts every transfer;
// a byte that releases several bytes holds up the input until they drain,
// since the result queue drains one entry per transfer and is reloaded only as its last entry leaves.
// An apostrophe at a token boundary is held until one or two later bytes
// decide a contraction, so output can lag input by up to two bytes; the end
// of text flushes everything and returns the splitter to idle.
// Reset (rst_n low, synchronous) empties the input register and the queue
// and puts the splitter in the idle state. When the receiver stalls, the
// queue holds its bytes and in_tready drops once the input register is full.
module bpe_pretoken_splitter_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // end_of_text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // [0] token_start
  output logic       out_tlast   // text_last
);

  logic                in_v_r;
  logic [7:0]          in_byte_r;
  logic                in_last_r;
  bps_pkg::st_t        st_r, st_nxt;
  bps_pkg::ent_t [2:0] ents;
  logic [1:0]          n_ents;
  logic                can_load;
  logic                advance;

  // the held byte moves into the split stage only when the queue can take it
  assign advance   = in_v_r && can_load;
  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (!rst_n) begin
      in_v_r <= 1'b0;
      st_r   <= '{cls: bps_pkg::CLS_IDLE, la0: 8'h00, la1: 8'h00, cnt: 2'd0};
    end else begin
      if (in_tready) in_v_r <= in_tvalid;
      if (advance)   st_r   <= st_nxt;
    end
  end

  bps_step u_step (
    .cur    (st_r),
    .data_b (in_byte_r),
    .eot    (in_last_r),
    .nxt    (st_nxt),
    .ents   (ents),
    .n_ents (n_ents)
  );

  bps_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .ld_ents    (ents),
    .ld_cnt     (n_ents),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_held_iff_apos: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.cnt != 2'd0) == (st_r.cls == bps_pkg::CLS_APOS))
    else $error("lookahead count out of step with run class");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.cnt != 2'd3)
    else $error("lookahead count above two");

  a_eot_idle: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_last_r |=> st_r.cls == bps_pkg::CLS_IDLE && st_r.cnt == 2'd0)
    else $error("splitter not idle after end of text");

  a_eot_emits: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_last_r |-> n_ents != 2'd0)
    else $error("end of text released no byte");

endmodule

// File: rtl/bps_step.sv
// Per-byte split logic: next state and up to three released bytes.
module bps_step (
  input  bps_pkg::st_t       cur,
  input  logic [7:0]         data_b,
  input  logic               eot,
  output bps_pkg::st_t       nxt,
  output bps_pkg::ent_t [2:0] ents,
  output logic [1:0]         n_ents
);

  bps_pkg::take_t t;
  bps_pkg::cls_t  tcls;
  logic           use_t;
  logic [7:0]     lb;
  logic [7:0]     want;

  assign lb   = bps_pkg::to_lower(data_b);
  assign want = (bps_pkg::to_lower(cur.la1) == bps_pkg::CH_L) ? bps_pkg::CH_L : bps_pkg::CH_E;
  // run the byte continues: open run, or the one left by a failed contraction
  assign tcls = (cur.cls != bps_pkg::CLS_APOS) ? cur.cls :
                (cur.cnt == 2'd1) ? bps_pkg::CLS_PUNCT : bps_pkg::CLS_LETTER;
  assign t    = bps_pkg::take_plain(tcls, data_b);

  always_comb begin
    ents   = '0;
    n_ents = 2'd0;
    nxt    = cur;
    use_t  = 1'b0;
    if (cur.cls == bps_pkg::CLS_APOS && cur.cnt == 2'd1) begin
      if (lb == bps_pkg::CH_S || lb == bps_pkg::CH_T || lb == bps_pkg::CH_M ||
          lb == bps_pkg::CH_D) begin
        ents[0] = '{data: cur.la0, start: 1'b1, last: 1'b0};
        ents[1] = '{data: data_b,  start: 1'b0, last: 1'b0};
        n_ents  = 2'd2;
        nxt.cnt = 2'd0;
        nxt.cls = bps_pkg::CLS_IDLE;
      end else if (lb == bps_pkg::CH_R || lb == bps_pkg::CH_V || lb == bps_pkg::CH_L) begin
        nxt.la1 = data_b;
        nxt.cnt = 2'd2;
      end else begin
        // not a contraction: apostrophe opens a punctuation run
        ents[0] = '{data: cur.la0, start: 1'b1, last: 1'b0};
        n_ents  = 2'd1;
        nxt.cnt = 2'd0;
        use_t   = 1'b1;
      end
    end else if (cur.cls == bps_pkg::CLS_APOS) begin
      if (lb == want) begin
        ents[0] = '{data: cur.la0, start: 1'b1, last: 1'b0};
        ents[1] = '{data: cur.la1, start: 1'b0, last: 1'b0};
        ents[2] = '{data: data_b,  start: 1'b0, last: 1'b0};
        n_ents  = 2'd3;
        nxt.cnt = 2'd0;
        nxt.cls = bps_pkg::CLS_IDLE;
      end else begin
        // held r/v/l opens a letter run
        ents[0] = '{data: cur.la0, start: 1'b1, last: 1'b0};
        ents[1] = '{data: cur.la1, start: 1'b1, last: 1'b0};
        n_ents  = 2'd2;
        nxt.cnt = 2'd0;
        use_t   = 1'b1;
      end
    end else begin
      use_t = 1'b1;
    end

    if (use_t) begin
      nxt.cls = t.cls;
      if (t.emit) begin
        ents[n_ents] = '{data: data_b, start: t.start, last: 1'b0};
        n_ents       = n_ents + 2'd1;
      end
      if (t.hold) begin
        nxt.la0 = data_b;
        nxt.cnt = 2'd1;
      end
    end

    // end of text: flush held bytes, each opens a pre-token
    if (eot) begin
      if (nxt.cnt != 2'd0) begin
        ents[n_ents] = '{data: nxt.la0, start: 1'b1, last: 1'b0};
        n_ents       = n_ents + 2'd1;
      end
      if (nxt.cnt == 2'd2) begin
        ents[n_ents] = '{data: nxt.la1, start: 1'b1, last: 1'b0};
        n_ents       = n_ents + 2'd1;
      end
      nxt.cnt = 2'd0;
      nxt.cls = bps_pkg::CLS_IDLE;
      if (n_ents != 2'd0) ents[n_ents - 2'd1].last = 1'b1;
    end
  end

endmodule

// File: rtl/bps_out_queue.sv
// Result queue: loads up to three bytes at once, releases one per transfer.
module bps_out_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  bps_pkg::ent_t [2:0] ld_ents,
  input  logic [1:0]          ld_cnt,
  output logic                can_load,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tuser,
  output logic                out_tlast
);

  bps_pkg::ent_t [2:0] q_r, q_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                pop;

  assign out_tvalid = (cnt_r != 2'd0);
  assign pop        = out_tvalid && out_tready;
  assign can_load   = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_tready);
  assign out_tdata  = q_r[0].data;
  assign out_tuser  = q_r[0].start;
  assign out_tlast  = q_r[0].last;

  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (load && can_load) begin
      q_nxt   = ld_ents;
      cnt_nxt = ld_cnt;
    end else if (pop) begin
      q_nxt[0] = q_r[1];
      q_nxt[1] = q_r[2];
      cnt_nxt  = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load && can_load && ld_cnt != 2'd0 |=> out_tvalid)
    else $error("queue loaded bytes but shows nothing");

endmodule

// File: tb/bpe_pretoken_splitter_top_test.sv
// Self-checking testbench for the streaming pre-token splitter.
module bpe_pretoken_splitter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Sink-side stall behavior, switched at random between phases.
  typedef enum int {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_SLOW,
    SINK_CHOKE
  } sink_mode_t;

  // Building blocks of the random texts.
  typedef enum int {
    FR_WORD,
    FR_CONTRACT,
    FR_BROKEN,
    FR_SPACE_WORD,
    FR_SPACE_PUNCT,
    FR_DIGITS,
    FR_NL_RUN,
    FR_PUNCT_NL,
    FR_WS_RUN,
    FR_NOISE
  } frag_t;

  // Generous fixed bound on the whole run.
  localparam int unsigned RUN_LIMIT_NS = 10_000_000;
  // Cycles to wait past the last expected byte; the pipe is two deep.
  localparam int unsigned TAIL_CYCLES  = 10;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tuser;
  logic       out_tlast;

  bpe_pretoken_splitter_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] data_byte
    .in_tlast   (in_tlast),    // end_of_text
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [7:0] out_byte
    .out_tuser  (out_tuser),   // [0] token_start
    .out_tlast  (out_tlast)    // text_last
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Splitter predictor state: open run kind plus the held apostrophe lookahead.
  // ---------------------------------------------------------------------------
  bps_pkg::cls_t run_kind = bps_pkg::CLS_IDLE;
  logic [7:0]    held[2];
  int            held_n   = 0;

  bps_pkg::ent_t step_q[$];      // bytes released by the byte being predicted
  bps_pkg::ent_t released_q[$];  // expected output bytes, oldest first
  logic [7:0]    text_q[$];      // text under construction on the send side

  int            errors     = 0;
  int            burst_left = 0;

  sink_mode_t    sink_mode  = SINK_OPEN;
  int            phase_left = 0;
  bps_pkg::ent_t want_ent;

  function automatic bit letter_b(input logic [7:0] b);
    return b[7] || (b >= bps_pkg::CH_LC_A && b <= bps_pkg::CH_LC_Z) ||
           (b >= bps_pkg::CH_UC_A && b <= bps_pkg::CH_UC_Z);
  endfunction

  function automatic bit digit_b(input logic [7:0] b);
    return b >= bps_pkg::CH_ZERO && b <= bps_pkg::CH_NINE;
  endfunction

  function automatic bit newline_b(input logic [7:0] b);
    return b == bps_pkg::CH_LF || b == bps_pkg::CH_CR;
  endfunction

  function automatic bit space_b(input logic [7:0] b);
    return b == bps_pkg::CH_SPACE || (b >= bps_pkg::CH_TAB && b <= bps_pkg::CH_CR);
  endfunction

  function automatic bit punct_b(input logic [7:0] b);
    return !(space_b(b) || letter_b(b) || digit_b(b));
  endfunction

  function automatic logic [7:0] fold_b(input logic [7:0] b);
    return (b >= bps_pkg::CH_UC_A && b <= bps_pkg::CH_UC_Z) ? b + 8'h20 : b;
  endfunction

  task automatic release_byte(input logic [7:0] b, input logic first);
    bps_pkg::ent_t e;
    e      = '{data: b, start: first, last: 1'b0};
    step_q = {step_q, e};
  endtask

  // Append one byte to the text under construction.
  task automatic add_byte(input logic [7:0] b);
    text_q = {text_q, b};
  endtask

  // Byte at a boundary: opens a new pre-token, or is held if an apostrophe.
  task automatic open_run(input logic [7:0] b);
    if (b == bps_pkg::CH_APOS) begin
      held[0]  = b;
      held_n   = 1;
      run_kind = bps_pkg::CLS_APOS;
    end else begin
      release_byte(b, 1'b1);
      if (newline_b(b))                run_kind = bps_pkg::CLS_NLRUN;
      else if (b == bps_pkg::CH_SPACE) run_kind = bps_pkg::CLS_SPACE1;
      else if (letter_b(b))            run_kind = bps_pkg::CLS_LETTER;
      else if (digit_b(b))             run_kind = bps_pkg::CLS_IDLE;   // digits stand alone
      else if (space_b(b))             run_kind = bps_pkg::CLS_WSRUN;
      else                             run_kind = bps_pkg::CLS_PUNCT;
    end
  endtask

  task automatic extend_or_open(input logic [7:0] b);
    bit            grow;
    bps_pkg::cls_t nxt;
    grow = 1'b0;
    nxt  = run_kind;
    case (run_kind)
      bps_pkg::CLS_NLRUN:   grow = space_b(b);
      bps_pkg::CLS_SPACE1: begin
        if (letter_b(b)) begin
          grow = 1'b1;
          nxt  = bps_pkg::CLS_LETTER;
        end else if (punct_b(b)) begin
          grow = 1'b1;
          nxt  = bps_pkg::CLS_PUNCT;
        end
      end
      bps_pkg::CLS_LETTER:  grow = letter_b(b);
      bps_pkg::CLS_PUNCT: begin
        if (punct_b(b)) begin
          grow = 1'b1;
        end else if (newline_b(b)) begin
          grow = 1'b1;
          nxt  = bps_pkg::CLS_PUNCTNL;
        end
      end
      bps_pkg::CLS_PUNCTNL: grow = newline_b(b);
      bps_pkg::CLS_WSRUN:   grow = space_b(b) && !newline_b(b);
      default:              grow = 1'b0;
    endcase
    if (grow) begin
      release_byte(b, 1'b0);
      run_kind = nxt;
    end else begin
      open_run(b);
    end
  endtask

  // Predict the bytes released by one accepted input transfer.
  task automatic split_byte(input logic [7:0] b, input bit eot);
    logic [7:0]    lb;
    logic [7:0]    want;
    bit            settled;
    bps_pkg::ent_t e;
    step_q.delete();
    settled = 1'b0;
    if (run_kind == bps_pkg::CLS_APOS) begin
      lb = fold_b(b);
      if (held_n == 1) begin
        if (lb == bps_pkg::CH_S || lb == bps_pkg::CH_T || lb == bps_pkg::CH_M ||
            lb == bps_pkg::CH_D) begin
          release_byte(held[0], 1'b1);
          release_byte(b, 1'b0);
          held_n   = 0;
          run_kind = bps_pkg::CLS_IDLE;
          settled  = 1'b1;
        end else if (lb == bps_pkg::CH_R || lb == bps_pkg::CH_V || lb == bps_pkg::CH_L) begin
          // two-letter suffix still open: hold this letter too
          held[1] = b;
          held_n  = 2;
          settled = 1'b1;
        end else begin
          // not a contraction: apostrophe opens a punct run, b goes on from there
          release_byte(held[0], 1'b1);
          held_n   = 0;
          run_kind = bps_pkg::CLS_PUNCT;
        end
      end else begin
        want = (fold_b(held[1]) == bps_pkg::CH_L) ? bps_pkg::CH_L : bps_pkg::CH_E;
        if (lb == want) begin
          release_byte(held[0], 1'b1);
          release_byte(held[1], 1'b0);
          release_byte(b, 1'b0);
          held_n   = 0;
          run_kind = bps_pkg::CLS_IDLE;
          settled  = 1'b1;
        end else begin
          // apostrophe alone, held r/v/l opens a letter run
          release_byte(held[0], 1'b1);
          release_byte(held[1], 1'b1);
          held_n   = 0;
          run_kind = bps_pkg::CLS_LETTER;
        end
      end
    end
    if (!settled) extend_or_open(b);
    if (eot) begin
      // end of text flushes the lookahead, each held byte its own pre-token
      for (int k = 0; k < held_n; k++) release_byte(held[k], 1'b1);
      held_n   = 0;
      run_kind = bps_pkg::CLS_IDLE;
    end
    for (int i = 0; i < step_q.size(); i++) begin
      e          = step_q[i];
      e.last     = eot && (i == step_q.size() - 1);
      released_q = {released_q, e};
    end
  endtask

  // ---------------------------------------------------------------------------
  // Send side. Called at a falling edge; returns at a falling edge at which
  // in_tvalid has not been assigned yet.
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input bit eot);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    split_byte(b, eot);
    @(negedge clk);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) push_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // Lowercase letter code, pushed in random case.
  task automatic add_cased(input logic [7:0] c);
    add_byte($urandom_range(0, 1) ? c : c - 8'h20);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    case ($urandom_range(0, 2))
      0:       c = bps_pkg::CH_LC_A + 8'($urandom_range(0, 25));
      1:       c = bps_pkg::CH_UC_A + 8'($urandom_range(0, 25));
      default: c = bps_pkg::CH_HIGH + 8'($urandom_range(0, 127));
    endcase
    return c;
  endfunction

  function automatic logic [7:0] rand_punct();
    case ($urandom_range(0, 7))
      0:       return 8'h21;
      1:       return 8'h2E;
      2:       return 8'h2C;
      3:       return bps_pkg::CH_APOS;
      4:       return 8'h00;
      5:       return 8'h7F;
      6:       return 8'h40;
      default: return 8'h7E;
    endcase
  endfunction

  function automatic logic [7:0] rand_ws();
    case ($urandom_range(0, 3))
      0:       return bps_pkg::CH_SPACE;
      1:       return bps_pkg::CH_TAB;
      2:       return 8'h0B;
      default: return 8'h0C;
    endcase
  endfunction

  function automatic logic [7:0] rand_nl();
    return $urandom_range(0, 1) ? bps_pkg::CH_LF : bps_pkg::CH_CR;
  endfunction

  // Mostly well-formed text with random content, salted with noise.
  task automatic build_text();
    frag_t      kind;
    logic [7:0] c;
    repeat ($urandom_range(1, 5)) begin
      kind = frag_t'($urandom_range(0, 9));
      case (kind)
        FR_WORD: repeat ($urandom_range(1, 6)) add_byte(rand_letter());
        FR_CONTRACT: begin
          add_byte(bps_pkg::CH_APOS);
          case ($urandom_range(0, 6))
            0: add_cased(bps_pkg::CH_S);
            1: add_cased(bps_pkg::CH_T);
            2: add_cased(bps_pkg::CH_M);
            3: add_cased(bps_pkg::CH_D);
            4: begin
              add_cased(bps_pkg::CH_R);
              add_cased(bps_pkg::CH_E);
            end
            5: begin
              add_cased(bps_pkg::CH_V);
              add_cased(bps_pkg::CH_E);
            end
            default: begin
              add_cased(bps_pkg::CH_L);
              add_cased(bps_pkg::CH_L);
            end
          endcase
        end
        FR_BROKEN: begin
          add_byte(bps_pkg::CH_APOS);
          case ($urandom_range(0, 3))
            0:       add_cased(bps_pkg::CH_R);
            1:       add_cased(bps_pkg::CH_V);
            2:       add_cased(bps_pkg::CH_L);
            default: ;
          endcase
          c = 8'($urandom_range(0, 255));
          add_byte(c);
        end
        FR_SPACE_WORD: begin
          add_byte(bps_pkg::CH_SPACE);
          repeat ($urandom_range(1, 4)) add_byte(rand_letter());
        end
        FR_SPACE_PUNCT: begin
          add_byte(bps_pkg::CH_SPACE);
          repeat ($urandom_range(1, 3)) add_byte(rand_punct());
        end
        FR_DIGITS: begin
          if ($urandom_range(0, 1)) add_byte(bps_pkg::CH_SPACE);
          repeat ($urandom_range(1, 3)) begin
            c = bps_pkg::CH_ZERO + 8'($urandom_range(0, 9));
            add_byte(c);
          end
        end
        FR_NL_RUN: begin
          add_byte(rand_nl());
          repeat ($urandom_range(0, 3)) add_byte(rand_ws());
        end
        FR_PUNCT_NL: begin
          repeat ($urandom_range(1, 3)) add_byte(rand_punct());
          repeat ($urandom_range(1, 2)) add_byte(rand_nl());
        end
        FR_WS_RUN: repeat ($urandom_range(1, 4)) add_byte(rand_ws());
        default: begin
          repeat ($urandom_range(1, 3)) begin
            c = 8'($urandom_range(0, 255));
            add_byte(c);
          end
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test tasks
  // ---------------------------------------------------------------------------

  // Contractions held and decided, uppercase suffix, failed one- and
  // two-letter suffixes, apostrophe after a joined space, byte extremes and
  // a two-byte lookahead flushed by end of text.
  task automatic test_contractions();
    add_str("'s'vE'rx 'd'q");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_str("'r");
    send_text();
  endtask

  // Space before a digit, digit, newline run with spaces, punct run into newline.
  task automatic test_char_classes();
    add_str(" 1\n \t!\n");
    send_text();
  endtask

  task automatic test_random_text(input int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      build_text();
      sent += text_q.size();
      send_text();
    end
  endtask

  // Sender holds off until every expected byte has drained.
  task automatic test_drain_pause();
    in_tvalid <= 1'b0;
    while (released_q.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Texts made only of raw random bytes.
  task automatic test_raw_bytes(input int n_items);
    int         sent;
    logic [7:0] c;
    sent = 0;
    while (sent < n_items) begin
      repeat ($urandom_range(1, 8)) begin
        c = 8'($urandom_range(0, 255));
        add_byte(c);
      end
      sent += text_q.size();
      send_text();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stall pattern, driven on the falling edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (phase_left == 0) begin
      sink_mode  = sink_mode_t'($urandom_range(0, 3));
      phase_left = $urandom_range(8, 40);
    end else begin
      phase_left--;
    end
    case (sink_mode)
      SINK_OPEN:   out_tready <= 1'b1;
      SINK_RANDOM: out_tready <= 1'($urandom_range(0, 1));
      SINK_SLOW:   out_tready <= (phase_left % 4 == 0);
      default:     out_tready <= (phase_left < 4);   // long stall, short release
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output checker: each output transfer against the oldest expected byte.
  // Sampled at the rising edge, before the design's registers update.
  // ---------------------------------------------------------------------------
  task automatic flag(input string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (released_q.size() == 0) begin
        flag($sformatf("unexpected output byte %02h start %0b last %0b",
                       out_tdata, out_tuser, out_tlast));
      end else begin
        want_ent = released_q.pop_front();
        if (out_tdata !== want_ent.data || out_tuser !== want_ent.start ||
            out_tlast !== want_ent.last) begin
          flag($sformatf("mismatch: expected byte %02h start %0b last %0b, got %02h %0b %0b",
                         want_ent.data, want_ent.start, want_ent.last,
                         out_tdata, out_tuser, out_tlast));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_contractions();
    test_char_classes();
    test_random_text(70);
    test_drain_pause();
    test_raw_bytes(20);
    test_random_text(40);

    in_tvalid <= 1'b0;
    while (released_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && released_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: files.f
rtl/bps_pkg.sv
rtl/bps_step.sv
rtl/bps_out_queue.sv
rtl/bpe_pretoken_splitter_top.sv
tb/bpe_pretoken_splitter_top_test.sv
